### rtl/isde_pkg.sv
`timescale 1ns / 1ps
// isde_pkg: constants, request and mode codes, entry state type and helper functions
// for the imprecise sharer directory entry; no dependencies

package isde_pkg;

	localparam int MESH_WIDTH    = 4;
	localparam int MESH_HEIGHT   = 4;
	localparam int POINTER_LIMIT = 2;
	localparam int WORD_BITS     = 4;
	localparam int GROUP_SIZE    = 2;

	localparam int NUM_NODES  = MESH_WIDTH * MESH_HEIGHT;
	localparam int NUM_GROUPS = POINTER_LIMIT * WORD_BITS;
	localparam int NODE_W     = 4;
	localparam int MASK_W     = 16;
	localparam int REQ_W      = 2;
	localparam int MODE_W     = 2;
	localparam int DIST_W     = 3;
	localparam int DIST_MAX   = 7;
	localparam int RAW_W      = $clog2(MESH_WIDTH + MESH_HEIGHT - 1);

	localparam logic [REQ_W-1:0] REQ_ADD    = 2'd0;
	localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
	localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;
	localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd3;

	localparam logic [MODE_W-1:0] MODE_LP     = 2'd0;
	localparam logic [MODE_W-1:0] MODE_COARSE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_DIST   = 2'd2;
	localparam logic [MODE_W-1:0] MODE_RSVD   = 2'd3;

	typedef struct packed {
		logic [MASK_W-1:0]     precise_bits;
		logic                  widened;
		logic [NUM_GROUPS-1:0] group_bits;
		logic [NODE_W-1:0]     home_node;
		logic                  distance_valid;
		logic [DIST_W-1:0]     max_distance;
	} isde_state_t;

	// nodes that exist in the mesh, within the visible mask
	function automatic logic [MASK_W-1:0] all_nodes();
		logic [MASK_W-1:0] m;
		m = '0;
		for (int n = 0; n < MASK_W; n++) begin
			m[n] = (n < NUM_NODES);
		end
		return m;
	endfunction

	function automatic logic [RAW_W-1:0] manhattan(logic [NODE_W-1:0] a, logic [NODE_W-1:0] b);
		int unsigned ra;
		int unsigned rb;
		int unsigned ca;
		int unsigned cb;
		int unsigned dr;
		int unsigned dc;
		ra = int'(a) / MESH_WIDTH;
		rb = int'(b) / MESH_WIDTH;
		ca = int'(a) % MESH_WIDTH;
		cb = int'(b) % MESH_WIDTH;
		dr = (ra > rb) ? ra - rb : rb - ra;
		dc = (ca > cb) ? ca - cb : cb - ca;
		return RAW_W'(dr + dc);
	endfunction

	// group bit for one node, none when the group is out of range
	function automatic logic [NUM_GROUPS-1:0] group_of(logic [NODE_W-1:0] node);
		logic [NUM_GROUPS-1:0] g;
		g = '0;
		for (int k = 0; k < NUM_GROUPS; k++) begin
			g[k] = ((int'(node) / GROUP_SIZE) == k);
		end
		return g;
	endfunction

	function automatic logic [NUM_GROUPS-1:0] fold_groups(logic [MASK_W-1:0] pb);
		logic [NUM_GROUPS-1:0] g;
		g = '0;
		for (int n = 0; n < MASK_W; n++) begin
			if (n < NUM_NODES && (n / GROUP_SIZE) < NUM_GROUPS && pb[n]) begin
				g[n / GROUP_SIZE] = 1'b1;
			end
		end
		return g;
	endfunction

endpackage

### rtl/isde_req_if.sv
`timescale 1ns / 1ps
// isde_req_if: request channel (valid, ready, req_type, node)
// depends on isde_pkg

interface isde_req_if;
	import isde_pkg::*;

	logic              valid;
	logic              ready;
	logic [REQ_W-1:0]  req_type;
	logic [NODE_W-1:0] node;

	modport source (output valid, output req_type, output node, input ready);
	modport sink (input valid, input req_type, input node, output ready);
endinterface

### rtl/isde_rsp_if.sv
`timescale 1ns / 1ps
// isde_rsp_if: result channel (valid, ready, sharer_mask, is_broadcast)
// depends on isde_pkg

interface isde_rsp_if;
	import isde_pkg::*;

	logic              valid;
	logic              ready;
	logic [MASK_W-1:0] sharer_mask;
	logic              is_broadcast;

	modport source (output valid, output sharer_mask, output is_broadcast, input ready);
	modport sink (input valid, input sharer_mask, input is_broadcast, output ready);
endinterface

### rtl/imprecise_sharer_directory_entry.sv
`timescale 1ns / 1ps
// imprecise_sharer_directory_entry: top level, input stage, entry state and result stage
// depends on isde_pkg, isde_req_if, isde_rsp_if, isde_update, isde_result
//
// channel  dir  payload                    transfer when
// req      in   req_type[1:0], node[3:0]   req.valid && req.ready
// rsp      out  sharer_mask[15:0], is_broadcast  rsp.valid && rsp.ready
// cfg      in   cfg_wdata[1:0]             cfg_we
//
// a request is registered, then the entry update and result run combinationally into the
// result register; one request per cycle sustained while the result side is not stalled
// arst_n clears mode, entry and both stage valids
// a stalled result holds; the input stage keeps taking requests while it can drain

module imprecise_sharer_directory_entry (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [isde_pkg::MODE_W-1:0] cfg_wdata,
	isde_req_if.sink                    req,
	isde_rsp_if.source                  rsp
);
	import isde_pkg::*;

	logic [MODE_W-1:0] rep_q;
	isde_state_t       state_q;
	isde_state_t       state_nxt;

	logic              valid_s1;
	logic [REQ_W-1:0]  req_type_s1;
	logic [NODE_W-1:0] node_s1;

	logic              valid_s2;
	logic [MASK_W-1:0] mask_s2;
	logic              bcast_s2;

	logic [MODE_W-1:0] mode;
	logic              advance;
	logic [MASK_W-1:0] mask_nxt;
	logic              bcast_nxt;

	assign mode      = (rep_q == MODE_RSVD) ? MODE_LP : rep_q;
	assign advance   = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	isde_update u_update (
		.mode     (mode),
		.req_type (req_type_s1),
		.node     (node_s1),
		.cur      (state_q),
		.nxt      (state_nxt)
	);

	isde_result u_result (
		.mode         (mode),
		.st           (state_nxt),
		.sharer_mask  (mask_nxt),
		.is_broadcast (bcast_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rep_q    <= MODE_LP;
			state_q  <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (req.ready) begin
				valid_s1 <= req.valid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (rsp.ready) begin
				valid_s2 <= 1'b0;
			end
			// mode write clears the entry
			if (cfg_we) begin
				rep_q   <= cfg_wdata;
				state_q <= '0;
			end else if (advance) begin
				state_q <= state_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_type_s1 <= req.req_type;
			node_s1     <= req.node;
		end
		if (advance) begin
			mask_s2  <= mask_nxt;
			bcast_s2 <= bcast_nxt;
		end
	end

	assign rsp.valid        = valid_s2;
	assign rsp.sharer_mask  = mask_s2;
	assign rsp.is_broadcast = bcast_s2;

endmodule

### rtl/isde_update.sv
`timescale 1ns / 1ps
// isde_update: next entry state for one request in the effective mode
// depends on isde_pkg

module isde_update (
	input  logic [isde_pkg::MODE_W-1:0] mode,
	input  logic [isde_pkg::REQ_W-1:0]  req_type,
	input  logic [isde_pkg::NODE_W-1:0] node,
	input  isde_pkg::isde_state_t       cur,
	output isde_pkg::isde_state_t       nxt
);
	import isde_pkg::*;

	logic                  on_mesh;
	logic [MASK_W-1:0]     added;
	logic                  overflow;
	logic [RAW_W-1:0]      dist_raw;
	logic [DIST_W-1:0]     dist_sat;

	assign on_mesh  = (int'(node) < NUM_NODES);
	assign added    = cur.precise_bits | (MASK_W'(1) << node);
	assign overflow = ($countones(added) > POINTER_LIMIT);
	assign dist_raw = manhattan(cur.home_node, node);
	assign dist_sat = (int'(dist_raw) > DIST_MAX) ? DIST_W'(DIST_MAX) : DIST_W'(dist_raw);

	always_comb begin
		nxt = cur;
		if (req_type == REQ_CLEAR) begin
			nxt = '0;
		end else if (req_type == REQ_ADD && on_mesh) begin
			unique case (mode)
				MODE_LP: begin
					if (!cur.widened) begin
						nxt.precise_bits = overflow ? all_nodes() : added;
						nxt.widened      = overflow;
					end
				end
				MODE_COARSE: begin
					if (!cur.widened) begin
						if (overflow) begin
							nxt.widened      = 1'b1;
							nxt.group_bits   = fold_groups(added);
							nxt.precise_bits = '0;
						end else begin
							nxt.precise_bits = added;
						end
					end else begin
						nxt.group_bits = cur.group_bits | group_of(node);
					end
				end
				default: begin
					if (!cur.distance_valid) begin
						nxt.home_node      = node;
						nxt.distance_valid = 1'b1;
						nxt.max_distance   = '0;
					end else if (dist_sat > cur.max_distance) begin
						nxt.max_distance = dist_sat;
					end
				end
			endcase
		end else if (req_type == REQ_REMOVE && on_mesh) begin
			if (mode == MODE_DIST) begin
				if (cur.distance_valid && cur.max_distance == '0 && node == cur.home_node) begin
					nxt.distance_valid = 1'b0;
				end
			end else if (!cur.widened) begin
				nxt.precise_bits = cur.precise_bits & ~(MASK_W'(1) << node);
			end
		end
	end

endmodule

### rtl/isde_result.sv
`timescale 1ns / 1ps
// isde_result: sharer mask and broadcast flag for an entry state
// depends on isde_pkg

module isde_result (
	input  logic [isde_pkg::MODE_W-1:0] mode,
	input  isde_pkg::isde_state_t       st,
	output logic [isde_pkg::MASK_W-1:0] sharer_mask,
	output logic                        is_broadcast
);
	import isde_pkg::*;

	logic [MASK_W-1:0] coarse_mask;
	logic [MASK_W-1:0] dist_mask;

	always_comb begin
		coarse_mask = '0;
		dist_mask   = '0;
		for (int n = 0; n < MASK_W; n++) begin
			if (n < NUM_NODES && (n / GROUP_SIZE) < NUM_GROUPS) begin
				coarse_mask[n] = st.group_bits[n / GROUP_SIZE];
			end
			if (n < NUM_NODES) begin
				dist_mask[n] = st.distance_valid &&
					(int'(manhattan(NODE_W'(n), st.home_node)) <= int'(st.max_distance));
			end
		end
	end

	always_comb begin
		unique case (mode)
			MODE_LP: begin
				sharer_mask  = st.precise_bits;
				is_broadcast = st.widened;
			end
			MODE_COARSE: begin
				sharer_mask  = st.widened ? coarse_mask : st.precise_bits;
				is_broadcast = st.widened && (st.group_bits == '1);
			end
			default: begin
				sharer_mask  = dist_mask;
				is_broadcast = (dist_mask == all_nodes());
			end
		endcase
	end

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking bench for imprecise_sharer_directory_entry; directed and random requests
// under every sharer representation, each result checked against a sharer-set predictor
// depends on isde_pkg, isde_req_if, isde_rsp_if and the rtl top level

module tb_top;
	import isde_pkg::*;

	localparam int IDLE_LIMIT   = 2000;
	localparam int RANDOM_ITEMS = 1200;

	class sharer_scoreboard;
		typedef struct {
			logic [MASK_W-1:0] mask;
			logic              bcast;
		} sharer_view_t;

		sharer_view_t          expected_views[$];
		int                    errors;
		logic [MODE_W-1:0]     mode;
		logic [MASK_W-1:0]     precise;
		logic                  widened;
		logic [NUM_GROUPS-1:0] groups;
		logic [NODE_W-1:0]     home;
		logic                  dist_valid;
		logic [DIST_W-1:0]     max_dist;

		function new();
			errors = 0;
			mode = MODE_LP;
			wipe();
		endfunction

		function void wipe();
			precise = '0;
			widened = 1'b0;
			groups = '0;
			home = '0;
			dist_valid = 1'b0;
			max_dist = '0;
		endfunction

		function void set_mode(logic [MODE_W-1:0] m);
			mode = m;
			wipe();
		endfunction

		function int hops(int a, int b);
			int dr;
			int dc;
			dr = a / MESH_WIDTH - b / MESH_WIDTH;
			dc = a % MESH_WIDTH - b % MESH_WIDTH;
			if (dr < 0) dr = -dr;
			if (dc < 0) dc = -dc;
			return dr + dc;
		endfunction

		function void fold_in(int n);
			if (n / GROUP_SIZE < NUM_GROUPS) groups[n / GROUP_SIZE] = 1'b1;
		endfunction

		function logic [MASK_W-1:0] mesh_nodes();
			logic [MASK_W-1:0] m;
			m = '0;
			for (int n = 0; n < MASK_W; n++) m[n] = (n < NUM_NODES);
			return m;
		endfunction

		function logic [MASK_W-1:0] coarse_view();
			logic [MASK_W-1:0] m;
			m = '0;
			for (int g = 0; g < NUM_GROUPS; g++) begin
				for (int k = 0; k < GROUP_SIZE; k++) begin
					if (groups[g] && g * GROUP_SIZE + k < NUM_NODES && g * GROUP_SIZE + k < MASK_W)
						m[g * GROUP_SIZE + k] = 1'b1;
				end
			end
			return m;
		endfunction

		function logic [MASK_W-1:0] distance_view();
			logic [MASK_W-1:0] m;
			m = '0;
			if (dist_valid) begin
				for (int n = 0; n < NUM_NODES && n < MASK_W; n++)
					m[n] = (hops(n, int'(home)) <= int'(max_dist));
			end
			return m;
		endfunction

		function void note_request(logic [REQ_W-1:0] rt, logic [NODE_W-1:0] nd);
			logic [MODE_W-1:0] m;
			int                n;
			int                d;
			sharer_view_t      v;
			m = (mode == MODE_RSVD) ? MODE_LP : mode;
			n = int'(nd);
			if (rt == REQ_CLEAR) begin
				wipe();
			end else if (rt == REQ_ADD && n < NUM_NODES) begin
				if (m == MODE_DIST) begin
					if (!dist_valid) begin
						home = nd;
						dist_valid = 1'b1;
						max_dist = '0;
					end else begin
						d = hops(int'(home), n);
						if (d > DIST_MAX) d = DIST_MAX;
						if (d > int'(max_dist)) max_dist = DIST_W'(d);
					end
				end else if (!widened) begin
					precise[n] = 1'b1;
					if ($countones(precise) > POINTER_LIMIT) begin
						widened = 1'b1;
						if (m == MODE_LP) begin
							precise = mesh_nodes();
						end else begin
							for (int k = 0; k < NUM_NODES && k < MASK_W; k++)
								if (precise[k]) fold_in(k);
							precise = '0;
						end
					end
				end else if (m == MODE_COARSE) begin
					fold_in(n);
				end
			end else if (rt == REQ_REMOVE && n < NUM_NODES) begin
				if (m == MODE_DIST) begin
					if (dist_valid && max_dist == 0 && nd == home) dist_valid = 1'b0;
				end else if (!widened) begin
					precise[n] = 1'b0;
				end
			end

			if (m == MODE_LP) begin
				v.mask = precise;
				v.bcast = widened;
			end else if (m == MODE_COARSE) begin
				v.mask = widened ? coarse_view() : precise;
				v.bcast = widened && (groups == '1);
			end else begin
				v.mask = distance_view();
				v.bcast = (v.mask == mesh_nodes());
			end
			expected_views.push_back(v);
		endfunction

		function void check_result(logic [MASK_W-1:0] mask, logic bcast);
			sharer_view_t v;
			if (expected_views.size() == 0) begin
				$error("result with no request outstanding: sharer_mask %h, is_broadcast %b",
					mask, bcast);
				errors++;
				return;
			end
			v = expected_views.pop_front();
			if (mask !== v.mask) begin
				$error("sharer_mask: expected %h, actual %h", v.mask, mask);
				errors++;
			end
			if (bcast !== v.bcast) begin
				$error("is_broadcast: expected %b, actual %b", v.bcast, bcast);
				errors++;
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [MODE_W-1:0] cfg_wdata;

	isde_req_if req();
	isde_rsp_if rsp();

	sharer_scoreboard  board;
	int                results_seen;
	int                idle_cycles;
	bit                hold_request;
	bit                rsp_calm;
	bit                gaps_off;
	logic [NODE_W-1:0] last_added;

	imprecise_sharer_directory_entry i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic push(logic [REQ_W-1:0] rt, logic [NODE_W-1:0] nd);
		int gap;
		gap = gaps_off ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.req_type <= rt;
		req.node <= nd;
		do @(negedge clk); while (req.ready !== 1'b1);
		@(posedge clk);
		board.note_request(rt, nd);
		if (rt == REQ_ADD) last_added = nd;
	endtask

	task automatic drain();
		req.valid <= 1'b0;
		while (board.expected_views.size() != 0) @(posedge clk);
		@(posedge clk);
	endtask

	task automatic set_mode(logic [MODE_W-1:0] m);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.set_mode(m);
	endtask

	// result side: random stalls, calm stretches and long holds on request
	initial begin
		int                stall;
		logic [MASK_W-1:0] mask;
		logic              bc;
		rsp.ready <= 1'b0;
		results_seen = 0;
		rsp_calm = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_request) begin
				stall = $urandom_range(60, 90);
				hold_request = 1'b0;
			end else begin
				stall = rsp_calm ? 0 : $urandom_range(0, 8);
			end
			if (stall > 0) begin
				rsp.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp.ready <= 1'b1;
			do @(negedge clk); while (rsp.valid !== 1'b1);
			mask = rsp.sharer_mask;
			bc = rsp.is_broadcast;
			@(posedge clk);
			board.check_result(mask, bc);
			results_seen++;
			if (results_seen % 64 == 0) rsp_calm = ($urandom_range(0, 3) == 0);
		end
	end

	// no transfer for too long means the block hung
	initial begin
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(negedge clk);
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || cfg_we)
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		int                sent;
		int                phase;
		int                plen;
		int                clear_pct;
		int                pause_at;
		int                r;
		logic [REQ_W-1:0]  rt;
		logic [NODE_W-1:0] nd;
		board = new();
		hold_request = 1'b0;
		gaps_off = 1'b0;
		last_added = '0;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= MODE_LP;
		req.valid <= 1'b0;
		req.req_type <= REQ_QUERY;
		req.node <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// limited pointers: exact set, overflow to broadcast, ignored remove and add
		set_mode(MODE_LP);
		push(REQ_ADD, 4'd0);
		push(REQ_ADD, 4'd15);
		push(REQ_REMOVE, 4'd15);
		push(REQ_ADD, 4'd5);
		push(REQ_ADD, 4'd9);
		push(REQ_REMOVE, 4'd5);
		push(REQ_ADD, 4'd3);
		push(REQ_CLEAR, 4'd0);
		// coarse vector: fold on overflow, later adds set groups, remove ignored
		set_mode(MODE_COARSE);
		push(REQ_ADD, 4'd1);
		push(REQ_ADD, 4'd14);
		push(REQ_ADD, 4'd6);
		push(REQ_REMOVE, 4'd1);
		push(REQ_ADD, 4'd10);
		// distance: home, remove of lone home, growth to full mesh
		set_mode(MODE_DIST);
		push(REQ_ADD, 4'd5);
		push(REQ_REMOVE, 4'd5);
		push(REQ_ADD, 4'd5);
		push(REQ_ADD, 4'd5);
		push(REQ_ADD, 4'd0);
		push(REQ_REMOVE, 4'd5);
		push(REQ_CLEAR, 4'd0);
		push(REQ_ADD, 4'd0);
		push(REQ_ADD, 4'd15);
		// unused mode value acts as limited pointers
		set_mode(MODE_RSVD);
		push(REQ_ADD, 4'd2);
		push(REQ_ADD, 4'd4);
		push(REQ_ADD, 4'd8);
		push(REQ_QUERY, 4'd15);

		sent = 0;
		phase = 0;
		while (sent < RANDOM_ITEMS) begin
			if (phase < 4)
				set_mode(MODE_W'(phase));
			else
				set_mode(MODE_W'($urandom_range(0, 3)));
			plen = $urandom_range(20, 120);
			gaps_off = ($urandom_range(0, 3) == 0);
			if (phase == 4 || phase == 9) begin
				gaps_off = 1'b1;
				hold_request = 1'b1;
				plen = 150;
			end
			clear_pct = $urandom_range(1, 12);
			pause_at = ($urandom_range(0, 3) == 0) ? plen / 2 : -1;
			for (int i = 0; i < plen; i++) begin
				if (i == pause_at) drain();
				r = $urandom_range(0, 99);
				if (r < clear_pct) begin
					rt = REQ_CLEAR;
				end else begin
					r = $urandom_range(0, 99);
					rt = (r < 60) ? REQ_ADD : ((r < 85) ? REQ_REMOVE : REQ_QUERY);
				end
				nd = ($urandom_range(0, 9) < 3) ? last_added
					: NODE_W'($urandom_range(0, 2 ** NODE_W - 1));
				push(rt, nd);
			end
			sent += plen;
			phase++;
		end

		drain();
		repeat (20) @(posedge clk);
		if (board.expected_views.size() != 0) begin
			$error("%0d results never arrived", board.expected_views.size());
			board.errors++;
		end
		if (board.errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

### imprecise_sharer_directory_entry.f
rtl/isde_pkg.sv
rtl/isde_req_if.sv
rtl/isde_rsp_if.sv
rtl/isde_update.sv
rtl/isde_result.sv
rtl/imprecise_sharer_directory_entry.sv
verif/tb_top.sv
